// ----- rtl/core/dpt_pkg.sv -----
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared constants for the dynamic priority task picker.
// ----------------------------------------------------------------------------
package dpt_pkg;

  // Default build sizes
  localparam int unsigned EntriesDef  = 8;
  localparam int unsigned TimeBitsDef = 16;
  localparam int unsigned PrioBitsDef = 16;

  // Fixed port field widths
  localparam int unsigned IdxFieldW  = 3;
  localparam int unsigned TimeFieldW = 16;
  localparam int unsigned PrioFieldW = 16;

  // Request action codes
  localparam logic ActLoad = 1'b0;
  localparam logic ActTick = 1'b1;

endpackage

// ----- rtl/core/dynamic_priority_task_picker.sv -----
// ----------------------------------------------------------------------------
// dynamic_priority_task_picker
// Ring of task entries (time, priority) served by highest dynamic priority.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  -----------------------------------
// request   in         start_i & !busy_o    action_i, entry_index_i,
//                                           load_time_i, load_priority_i
// result    out        done_o (one cycle)   ran_valid_o, ran_index_o,
//                                           time_left_o, priority_left_o,
//                                           all_done_o
//
// Load: done_o pulses the cycle after the request is taken and busy_o stays
//   low, so the next request can follow right away.
// Tick: busy_o stays high while one entry per cycle is read from the task
//   RAM, then through a write-back state; done_o pulses the cycle after.
// Reset clears the active bits and the ring pointer; the task RAM itself is
//   not cleared, since an inactive entry is never compared or served.
// The result side cannot stall: done_o pulses for one cycle; fields then hold.
//
// Notes:
// - An entry is active exactly when its time is nonzero, so the pointer
//   skip to the first nonzero-time entry folds into the scan: the scan starts
//   at the last served entry and keeps the first active entry with the
//   strictly highest priority in ring order.
// ----------------------------------------------------------------------------
module dynamic_priority_task_picker
  import dpt_pkg::*;
#(
  parameter int unsigned ENTRIES   = EntriesDef,
  parameter int unsigned TIME_BITS = TimeBitsDef,
  parameter int unsigned PRIO_BITS = PrioBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  action_i,
  input  logic [IdxFieldW-1:0]  entry_index_i,
  input  logic [TimeFieldW-1:0] load_time_i,
  input  logic [PrioFieldW-1:0] load_priority_i,
  // result
  output logic                  done_o,
  output logic                  ran_valid_o,
  output logic [IdxFieldW-1:0]  ran_index_o,
  output logic [TimeFieldW-1:0] time_left_o,
  output logic [PrioFieldW-1:0] priority_left_o,
  output logic                  all_done_o
);

  localparam int unsigned IdxW  = $clog2(ENTRIES);
  localparam int unsigned WordW = TIME_BITS + PRIO_BITS;
  localparam int unsigned CmpW  = ((IdxW > IdxFieldW) ? IdxW : IdxFieldW) + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWb
  } state_e;

  state_e               state_q, state_d;
  logic [ENTRIES-1:0]   act_q, act_d;
  logic [IdxW-1:0]      ptr_q, ptr_d;     // last served entry
  logic [IdxW-1:0]      idx_q, idx_d;     // entry whose read data is in rdata
  logic [IdxW-1:0]      cnt_q, cnt_d;     // entries compared so far
  logic                 found_q, found_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic [TIME_BITS-1:0] best_time_q, best_time_d;
  logic [PRIO_BITS-1:0] best_prio_q, best_prio_d;

  logic                  done_q, done_d;
  logic                  ran_valid_q, ran_valid_d;
  logic [IdxFieldW-1:0]  ran_index_q, ran_index_d;
  logic [TimeFieldW-1:0] time_left_q, time_left_d;
  logic [PrioFieldW-1:0] prio_left_q, prio_left_d;
  logic                  all_done_q, all_done_d;

  // RAM ports
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [WordW-1:0]     ram_wdata;
  logic [IdxW-1:0]      ram_raddr;
  logic [WordW-1:0]     ram_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [PRIO_BITS-1:0] rd_prio;

  logic                 accept;
  logic                 ld_in_range;
  logic [TIME_BITS-1:0] ld_time;
  logic [PRIO_BITS-1:0] ld_prio;
  logic [IdxW-1:0]      ld_idx;
  logic [IdxW-1:0]      idx_next;
  logic                 take;
  logic [TIME_BITS-1:0] new_time;
  logic [PRIO_BITS-1:0] new_prio;

  dpt_task_ram #(
    .Depth (ENTRIES),
    .Width (WordW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_time = ram_rdata[WordW-1:PRIO_BITS];
  assign rd_prio = ram_rdata[PRIO_BITS-1:0];

  assign accept      = start_i && (state_q == StIdle);
  assign ld_in_range = CmpW'(entry_index_i) < CmpW'(ENTRIES);
  assign ld_time     = TIME_BITS'(load_time_i);
  assign ld_prio     = PRIO_BITS'(load_priority_i);
  assign ld_idx      = IdxW'(entry_index_i);
  assign idx_next    = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  // scan compare: first active entry wins, later ones need a strictly higher prio
  assign take = act_q[idx_q] && (!found_q || (rd_prio > best_prio_q));

  // served entry after its decrement (it is active, so time is nonzero)
  assign new_time = best_time_q - 1'b1;
  assign new_prio = (best_prio_q != '0) ? best_prio_q - 1'b1 : best_prio_q;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    best_prio_d = best_prio_q;
    done_d      = 1'b0;
    ran_valid_d = ran_valid_q;
    ran_index_d = ran_index_q;
    time_left_d = time_left_q;
    prio_left_d = prio_left_q;
    all_done_d  = all_done_q;
    ram_we      = 1'b0;
    ram_waddr   = ld_idx;
    ram_wdata   = {ld_time, ld_prio};
    ram_raddr   = idx_next;

    unique case (state_q)
      StIdle: begin
        ram_raddr = ptr_q;
        if (accept) begin
          if (action_i == ActLoad) begin
            if (ld_in_range) begin
              ram_we        = 1'b1;
              act_d[ld_idx] = (ld_time != '0);
            end
            ptr_d       = '0;
            done_d      = 1'b1;
            ran_valid_d = 1'b0;
            ran_index_d = '0;
            time_left_d = '0;
            prio_left_d = '0;
            all_done_d  = ~|act_d;
          end else begin
            idx_d   = ptr_q;
            cnt_d   = '0;
            found_d = 1'b0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        if (take) begin
          found_d     = 1'b1;
          best_idx_d  = idx_q;
          best_time_d = rd_time;
          best_prio_d = rd_prio;
        end
        idx_d = idx_next;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = StWb;
        end
      end
      StWb: begin
        ram_waddr = best_idx_q;
        ram_wdata = {new_time, new_prio};
        done_d    = 1'b1;
        if (found_q) begin
          ram_we            = 1'b1;
          act_d[best_idx_q] = (new_time != '0);
          ptr_d             = best_idx_q;
          ran_valid_d       = 1'b1;
          ran_index_d       = IdxFieldW'(best_idx_q);
          time_left_d       = TimeFieldW'(new_time);
          prio_left_d       = PrioFieldW'(new_prio);
        end else begin
          ran_valid_d = 1'b0;
          ran_index_d = '0;
          time_left_d = '0;
          prio_left_d = '0;
        end
        all_done_d = ~|act_d;
        state_d    = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      act_q       <= '0;
      ptr_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_time_q <= '0;
      best_prio_q <= '0;
      done_q      <= 1'b0;
      ran_valid_q <= 1'b0;
      ran_index_q <= '0;
      time_left_q <= '0;
      prio_left_q <= '0;
      all_done_q  <= 1'b1;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      ptr_q       <= ptr_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      best_idx_q  <= best_idx_d;
      best_time_q <= best_time_d;
      best_prio_q <= best_prio_d;
      done_q      <= done_d;
      ran_valid_q <= ran_valid_d;
      ran_index_q <= ran_index_d;
      time_left_q <= time_left_d;
      prio_left_q <= prio_left_d;
      all_done_q  <= all_done_d;
    end
  end

  assign busy_o          = (state_q != StIdle);
  assign done_o          = done_q;
  assign ran_valid_o     = ran_valid_q;
  assign ran_index_o     = ran_index_q;
  assign time_left_o     = time_left_q;
  assign priority_left_o = prio_left_q;
  assign all_done_o      = all_done_q;

endmodule

// ----- rtl/core/dpt_task_ram.sv -----
// ----------------------------------------------------------------------------
// dpt_task_ram
// Task entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpt_task_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/dpt_checker.sv -----
// ----------------------------------------------------------------------------
// dpt_checker
// Port-level checks for the dynamic priority task picker.
// ----------------------------------------------------------------------------
module dpt_checker
  import dpt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  action_i,
  input logic [IdxFieldW-1:0]  entry_index_i,
  input logic [TimeFieldW-1:0] load_time_i,
  input logic [PrioFieldW-1:0] load_priority_i,
  input logic                  done_o,
  input logic                  ran_valid_o,
  input logic [IdxFieldW-1:0]  ran_index_o,
  input logic [TimeFieldW-1:0] time_left_o,
  input logic [PrioFieldW-1:0] priority_left_o,
  input logic                  all_done_o
);

  // a load answers in the next cycle, never as a served task
  a_load_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == ActLoad) |=> (done_o && !ran_valid_o))
    else $error("load request not answered next cycle");

  // a tick holds the block busy while it scans
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == ActTick) |=> (busy_o && !done_o))
    else $error("tick request did not start a scan");

  // nothing served: result fields are zero
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ran_valid_o) |->
      (ran_index_o == '0 && time_left_o == '0 && priority_left_o == '0))
    else $error("unserved result carries nonzero fields");

  // a served task with time left keeps the ring busy
  a_live_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ran_valid_o && time_left_o != '0) |-> !all_done_o)
    else $error("all_done set while served task still has time");

endmodule

bind dynamic_priority_task_picker dpt_checker u_dpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .action_i        (action_i),
  .entry_index_i   (entry_index_i),
  .load_time_i     (load_time_i),
  .load_priority_i (load_priority_i),
  .done_o          (done_o),
  .ran_valid_o     (ran_valid_o),
  .ran_index_o     (ran_index_o),
  .time_left_o     (time_left_o),
  .priority_left_o (priority_left_o),
  .all_done_o      (all_done_o)
);
